[hw/rtl/acctilt_pkg.sv]
// ----------------------------------------------------------------------------
// acctilt_pkg: shared constants, types and the arctangent table
// Widths of the tilt pipeline stages, the side-band word that travels with
// each sample, and the per-stage CORDIC angle in 2^-16 degree.
// ----------------------------------------------------------------------------
package acctilt_pkg;

  // raw word and count widths
  localparam int WORD_W     = 16;
  localparam int WORD_SHIFT = 6;
  localparam int COUNT_W    = 10;

  // x^2 + y^2 fits 20 bits unsigned (max 2 * 512^2)
  localparam int SQ_W   = 20;
  // root of (sq << 32) carries 16 fraction bits, below 2^26
  localparam int FRAC_W = 16;
  localparam int ROOT_W = 26;
  localparam int REM_W  = 27;

  // CORDIC vector and angle accumulator widths
  localparam int XY_W   = 29;
  localparam int ACC_W  = 26;
  localparam int TAB_W  = 22;

  localparam int TABLE_LEN        = 24;
  localparam int ANGLE_STAGES_DEF = 16;

  // output scaling
  localparam int ANGLE_W     = 16;
  localparam int ROUND_SHIFT = 8;
  localparam int ROUND_HALF  = 128;
  localparam int FULL_ANGLE  = 23040;

  // side-band word carried beside the arithmetic
  typedef struct packed {
    logic               undef;   // all three axes zero
    logic               zzero;   // z axis zero
    logic               zneg;    // z axis negative
    logic [COUNT_W:0]   za;      // |z|, reaches 512
  } side_t;

  // atan(2^-i) in degrees, scaled by 2^16 and rounded
  function automatic logic [TAB_W-1:0] atan_q16(input int idx);
    logic [TAB_W-1:0] val;
    case (idx)
      0:       val = TAB_W'(2949120);
      1:       val = TAB_W'(1740967);
      2:       val = TAB_W'(919879);
      3:       val = TAB_W'(466945);
      4:       val = TAB_W'(234379);
      5:       val = TAB_W'(117304);
      6:       val = TAB_W'(58666);
      7:       val = TAB_W'(29335);
      8:       val = TAB_W'(14668);
      9:       val = TAB_W'(7334);
      10:      val = TAB_W'(3667);
      11:      val = TAB_W'(1833);
      12:      val = TAB_W'(917);
      13:      val = TAB_W'(458);
      14:      val = TAB_W'(229);
      15:      val = TAB_W'(115);
      16:      val = TAB_W'(57);
      17:      val = TAB_W'(29);
      18:      val = TAB_W'(14);
      19:      val = TAB_W'(7);
      20:      val = TAB_W'(4);
      21:      val = TAB_W'(2);
      22:      val = TAB_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/accelerometer_tilt_angle.sv]
// ----------------------------------------------------------------------------
// accelerometer_tilt_angle: tilt angle from three raw accelerometer words
// Pipelined: input capture, square sum, bit-per-stage square root, vectoring
// CORDIC, then rounding and sign.
// ----------------------------------------------------------------------------
// Usage:
//   Command side: drive x_word, y_word, z_word and pulse start. A word is
//   taken at every rising edge where start is high and busy is low; busy
//   is always low, so a new word may enter in every cycle.
//   Result side: done is high for exactly one cycle with tilt_angle (1/256
//   degree, signed, -90..+90) and angle_undefined (all axes zero).
//   Stages: one capture stage, one square-sum stage, 26 square-root stages
//   (one root bit each), ANGLE_STAGES CORDIC stages (capped at TABLE_LEN)
//   and one output stage.
//   Throughput: one word per cycle, results in start order.
//   Reset: rst clears all valid bits; nothing is in flight afterwards.
//   The receiver cannot stall; a result is shown once and never held.
// ----------------------------------------------------------------------------
module accelerometer_tilt_angle #(
  parameter int ANGLE_STAGES = acctilt_pkg::ANGLE_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [acctilt_pkg::WORD_W-1:0] x_word,
  input  logic signed [acctilt_pkg::WORD_W-1:0] y_word,
  input  logic signed [acctilt_pkg::WORD_W-1:0] z_word,
  output logic                                  done,
  output logic signed [acctilt_pkg::ANGLE_W-1:0] tilt_angle,
  output logic                                  angle_undefined
);

  localparam int COUNT_W = acctilt_pkg::COUNT_W;
  localparam int SQ_W    = acctilt_pkg::SQ_W;
  localparam int ROOT_W  = acctilt_pkg::ROOT_W;
  localparam int REM_W   = acctilt_pkg::REM_W;
  localparam int XY_W    = acctilt_pkg::XY_W;
  localparam int ACC_W   = acctilt_pkg::ACC_W;
  localparam int TAB_W   = acctilt_pkg::TAB_W;
  localparam int FRAC_W  = acctilt_pkg::FRAC_W;
  localparam int ANGLE_W = acctilt_pkg::ANGLE_W;
  localparam int CORDIC_N = (ANGLE_STAGES < acctilt_pkg::TABLE_LEN) ?
                            ANGLE_STAGES : acctilt_pkg::TABLE_LEN;
  localparam int SQ_PAIRS = SQ_W / 2;

  // pipeline never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: capture words, shift down to 10-bit counts
  // ---------------------------------------------------------------------------
  logic                                    valid1;
  logic signed [COUNT_W-1:0]               x1, y1, z1;
  logic signed [acctilt_pkg::WORD_W-1:0]   xs, ys, zs;

  assign xs = x_word >>> acctilt_pkg::WORD_SHIFT;
  assign ys = y_word >>> acctilt_pkg::WORD_SHIFT;
  assign zs = z_word >>> acctilt_pkg::WORD_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= xs[COUNT_W-1:0];
    y1 <= ys[COUNT_W-1:0];
    z1 <= zs[COUNT_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: x^2 + y^2, |z| and special-case flags
  // ---------------------------------------------------------------------------
  logic signed [2*COUNT_W-1:0] xx, yy;
  logic signed [COUNT_W:0]     z_ext, z_abs;
  acctilt_pkg::side_t          side_next;

  assign xx    = (2*COUNT_W)'(x1) * (2*COUNT_W)'(x1);
  assign yy    = (2*COUNT_W)'(y1) * (2*COUNT_W)'(y1);
  assign z_ext = {z1[COUNT_W-1], z1};
  assign z_abs = z1[COUNT_W-1] ? -z_ext : z_ext;

  always_comb begin
    side_next.undef = (x1 == '0) && (y1 == '0) && (z1 == '0);
    side_next.zzero = (z1 == '0);
    side_next.zneg  = z1[COUNT_W-1];
    side_next.za    = z_abs;
  end

  // square-root pipeline storage; index 0 is the square-sum stage
  logic                          sv   [ROOT_W+1];
  acctilt_pkg::side_t            sside[ROOT_W+1];
  logic [SQ_W-1:0]               ssq  [ROOT_W+1];
  logic [REM_W-1:0]              srem [ROOT_W+1];
  logic [ROOT_W-1:0]             sroot[ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    ssq[0]   <= SQ_W'($unsigned(xx)) + SQ_W'($unsigned(yy));
    sside[0] <= side_next;
    srem[0]  <= '0;
    sroot[0] <= '0;
  end

  // ---------------------------------------------------------------------------
  // Square root of (sq << 32): one root bit per stage, restoring method
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [1:0]       pair;
    logic [REM_W+1:0] rem_sh, trial, diff;
    logic             take;

    // next two radicand bits; the low 32 bits of the radicand are zero
    if (k < SQ_PAIRS) begin : g_pair
      assign pair = ssq[k][SQ_W-1-2*k -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {srem[k], pair};
    assign trial  = {1'b0, sroot[k], 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      ssq[k+1]   <= ssq[k];
      sside[k+1] <= sside[k];
      srem[k+1]  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      sroot[k+1] <= {sroot[k][ROOT_W-2:0], take};
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC from (|z| * 2^16, root)
  // ---------------------------------------------------------------------------
  logic                      cv   [CORDIC_N+1];
  acctilt_pkg::side_t        cside[CORDIC_N+1];
  logic signed [XY_W-1:0]    cx   [CORDIC_N+1];
  logic signed [XY_W-1:0]    cy   [CORDIC_N+1];
  logic signed [ACC_W-1:0]   ca   [CORDIC_N+1];

  assign cv[0]    = sv[ROOT_W];
  assign cside[0] = sside[ROOT_W];
  assign cx[0]    = signed'({{(XY_W-COUNT_W-1-FRAC_W){1'b0}}, sside[ROOT_W].za,
                             {FRAC_W{1'b0}}});
  assign cy[0]    = signed'({{(XY_W-ROOT_W){1'b0}}, sroot[ROOT_W]});
  assign ca[0]    = '0;

  for (genvar j = 0; j < CORDIC_N; j++) begin : g_cordic
    logic signed [XY_W-1:0]  dx, dy;
    logic signed [ACC_W-1:0] step;
    logic                    up;

    // shifts use the old vector and round toward minus infinity
    assign dx   = cy[j] >>> j;
    assign dy   = cx[j] >>> j;
    assign step = signed'({{(ACC_W-TAB_W){1'b0}}, acctilt_pkg::atan_q16(j)});
    assign up   = ~cy[j][XY_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[j+1] <= 1'b0;
      end else begin
        cv[j+1] <= cv[j];
      end
    end

    always_ff @(posedge clk) begin
      cside[j+1] <= cside[j];
      if (up) begin
        cx[j+1] <= cx[j] + dx;
        cy[j+1] <= cy[j] - dy;
        ca[j+1] <= ca[j] + step;
      end else begin
        cx[j+1] <= cx[j] - dx;
        cy[j+1] <= cy[j] + dy;
        ca[j+1] <= ca[j] - step;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: round to 1/256 degree, clamp, apply sign of z
  // ---------------------------------------------------------------------------
  acctilt_pkg::side_t       fside;
  logic signed [ACC_W-1:0]  rnd, rnd_sh, clamped;
  logic signed [ANGLE_W-1:0] theta, angle_next;

  assign fside  = cside[CORDIC_N];
  assign rnd    = ca[CORDIC_N] + ACC_W'(acctilt_pkg::ROUND_HALF);
  assign rnd_sh = rnd >>> acctilt_pkg::ROUND_SHIFT;

  always_comb begin
    if (rnd_sh < 0) begin
      clamped = '0;
    end else if (rnd_sh > signed'(ACC_W'(acctilt_pkg::FULL_ANGLE))) begin
      clamped = ACC_W'(acctilt_pkg::FULL_ANGLE);
    end else begin
      clamped = rnd_sh;
    end
    theta = clamped[ANGLE_W-1:0];

    if (fside.undef) begin
      angle_next = '0;
    end else if (fside.zzero) begin
      angle_next = ANGLE_W'(acctilt_pkg::FULL_ANGLE);
    end else if (fside.zneg) begin
      angle_next = -theta;
    end else begin
      angle_next = theta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    tilt_angle      <= angle_next;
    angle_undefined <= fside.undef;
  end

endmodule

[tb/tb_accelerometer_tilt_angle.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accelerometer_tilt_angle: self-checking bench for the tilt angle pipeline
// Drives raw accelerometer words through the start/busy port and predicts
// each tilt angle with an independent square-root and CORDIC model. Results
// are matched in order against the done strobe. Stimulus covers directed
// corners, zero-axis cases, random words and a back-to-back burst.
// ----------------------------------------------------------------------------
module tb_accelerometer_tilt_angle;

  localparam int WORD_W      = acctilt_pkg::WORD_W;
  localparam int WORD_SHIFT  = acctilt_pkg::WORD_SHIFT;
  localparam int FRAC_W      = acctilt_pkg::FRAC_W;
  localparam int ANGLE_W     = acctilt_pkg::ANGLE_W;
  localparam int ROUND_SHIFT = acctilt_pkg::ROUND_SHIFT;
  localparam int ROUND_HALF  = acctilt_pkg::ROUND_HALF;
  localparam int FULL_ANGLE  = acctilt_pkg::FULL_ANGLE;

  localparam int STAGES      = acctilt_pkg::ANGLE_STAGES_DEF;
  localparam int LATENCY     = STAGES + 28;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // per-stage rotation angle, 2^-16 degree
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      undef;
  } tilt_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [WORD_W-1:0]  x_word = '0;
  logic signed [WORD_W-1:0]  y_word = '0;
  logic signed [WORD_W-1:0]  z_word = '0;
  logic                      done;
  logic signed [ANGLE_W-1:0] tilt_angle;
  logic                      angle_undefined;

  tilt_t tilt_queue [$];
  int    mismatches = 0;
  int    cycles = 0;
  bit    gaps_on = 1'b1;

  accelerometer_tilt_angle #(
    .ANGLE_STAGES(STAGES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_word(x_word),
    .y_word(y_word),
    .z_word(z_word),
    .done(done),
    .tilt_angle(tilt_angle),
    .angle_undefined(angle_undefined)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL accelerometer_tilt_angle");
      $finish;
    end
  end

  // floor(sqrt(n)), bit-pair method
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned rem, res, probe;
    rem   = n;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // expected angle and flag for one word triple
  function automatic tilt_t tilt_of(input logic signed [WORD_W-1:0] xw,
                                    input logic signed [WORD_W-1:0] yw,
                                    input logic signed [WORD_W-1:0] zw);
    int              xc, yc, zc;
    longint unsigned root;
    longint          xa, ya, dx, dy, theta;
    tilt_t           res;
    xc = int'(xw) >>> WORD_SHIFT;
    yc = int'(yw) >>> WORD_SHIFT;
    zc = int'(zw) >>> WORD_SHIFT;
    res.angle = '0;
    res.undef = 1'b0;
    if (xc == 0 && yc == 0 && zc == 0) begin
      res.undef = 1'b1;
    end else if (zc == 0) begin
      res.angle = ANGLE_W'(FULL_ANGLE);
    end else begin
      root  = floor_root(longint'(xc * xc + yc * yc) << 32);
      xa    = longint'(zc < 0 ? -zc : zc) <<< FRAC_W;
      ya    = longint'(root);
      theta = 0;
      // vectoring rotations toward the x axis; shifts floor on signed values
      for (int i = 0; i < STAGES && i < 24; i++) begin
        dx = ya >>> i;
        dy = xa >>> i;
        if (ya >= 0) begin
          xa    = xa + dx;
          ya    = ya - dy;
          theta = theta + ATAN_Q16[i];
        end else begin
          xa    = xa - dx;
          ya    = ya + dy;
          theta = theta - ATAN_Q16[i];
        end
      end
      theta = (theta + ROUND_HALF) >>> ROUND_SHIFT;
      if (theta < 0) theta = 0;
      if (theta > FULL_ANGLE) theta = FULL_ANGLE;
      res.angle = ANGLE_W'(zc < 0 ? -theta : theta);
    end
    return res;
  endfunction

  // raw word holding a given count, with random bits below the count
  function automatic logic signed [WORD_W-1:0] word_of(input int count);
    return WORD_W'(count <<< WORD_SHIFT) | WORD_W'($urandom_range(63));
  endfunction

  function automatic logic signed [WORD_W-1:0] any_word();
    return WORD_W'($urandom);
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // hand one word to the block, with random idle cycles ahead of it while gaps_on is set
  task automatic send_word(input logic signed [WORD_W-1:0] xw,
                           input logic signed [WORD_W-1:0] yw,
                           input logic signed [WORD_W-1:0] zw);
    while (gaps_on && $urandom_range(99) < 12) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start  <= 1'b1;
    x_word <= xw;
    y_word <= yw;
    z_word <= zw;
    do @(posedge clk); while (busy);
    tilt_queue.push_back(tilt_of(xw, yw, zw));
  endtask

  // in-order result check
  always @(posedge clk) begin : check_results
    tilt_t want;
    if (!rst && done) begin
      if (tilt_queue.size() == 0) begin
        flag_error($sformatf("unexpected result: angle %0d undef %0b",
                             tilt_angle, angle_undefined));
      end else begin
        want = tilt_queue.pop_front();
        if (tilt_angle !== want.angle || angle_undefined !== want.undef)
          flag_error($sformatf("mismatch: angle exp %0d got %0d, undef exp %0b got %0b",
                               want.angle, tilt_angle, want.undef, angle_undefined));
      end
    end
  end

  // corners: zero axes, full-scale words, 45 degrees, sign of z
  task automatic test_directed();
    send_word(16'h0000, 16'h0000, 16'h0000);
    send_word(16'h003F, 16'h0020, 16'h0001);
    send_word(16'hFFFF, 16'h0000, 16'h0000);
    send_word(16'h0000, 16'h7FFF, 16'h0000);
    send_word(16'h0040, 16'h0000, 16'h003F);
    send_word(16'h0000, 16'h0000, 16'h7FFF);
    send_word(16'h0000, 16'h0000, 16'h8000);
    send_word(16'h8000, 16'h8000, 16'h0040);
    send_word(16'h8000, 16'h8000, 16'hFFC0);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h8000, 16'h8000);
    send_word(16'h0040, 16'h0000, 16'h0040);
    send_word(16'h0000, 16'hFFC0, 16'hFFC0);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h8000, 16'h7FFF, 16'h0040);
    send_word(16'h5555, 16'hAAAA, 16'h3333);
    send_word(16'hAAAA, 16'h5555, 16'hCCCC);
    send_word(16'hFFC0, 16'h0000, 16'h7FC0);
    send_word(16'h0000, 16'h0040, 16'h8000);
    send_word(16'h7FFF, 16'h0000, 16'hFFFF);
  endtask

  // z count zero, all counts zero, and x/y zero with random z
  task automatic test_zero_axes();
    repeat (100) begin
      case ($urandom_range(2))
        0:       send_word(any_word(), any_word(), word_of(0));
        1:       send_word(word_of(0), word_of(0), word_of(0));
        default: send_word(word_of(0), word_of(0), any_word());
      endcase
    end
  endtask

  // random words, small counts, and small z counts with random x and y
  task automatic test_random_words();
    int mag;
    repeat (700) begin
      mag = $urandom_range(3, 1);
      case ($urandom_range(9))
        6, 7:    send_word(word_of(int'($urandom_range(16)) - 8),
                           word_of(int'($urandom_range(16)) - 8),
                           word_of(int'($urandom_range(16)) - 8));
        8, 9:    send_word(any_word(), any_word(),
                           word_of($urandom_range(1) ? mag : -mag));
        default: send_word(any_word(), any_word(), any_word());
      endcase
    end
  endtask

  // one word per cycle, no idle cycles
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (330) send_word(any_word(), any_word(), any_word());
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_axes();
    test_random_words();
    test_back_to_back();
    @(negedge clk);
    start <= 1'b0;
    while (tilt_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS accelerometer_tilt_angle");
    end else begin
      $display("FAIL accelerometer_tilt_angle");
    end
    $finish;
  end

endmodule
